// ----- design/lbas_pkg.sv -----
// Package for the line bounded access splitter: widths, defaults, control structs.
package lbas_pkg;

  localparam int ThreadW = 8;
  localparam int AddrW   = 48;
  localparam int LenW    = 7;
  localparam int SizeW   = 4;

  localparam int LineBytesDef      = 64;
  localparam int MaxAccessBytesDef = 64;
  localparam int AddrBitsDef       = 48;

  typedef struct packed {
    logic load;
    logic advance;
  } lbas_cmd_t;

  typedef struct packed {
    logic len_nonzero;
    logic last;
  } lbas_sts_t;

endpackage

// ----- design/lbas_if.sv -----
// Request and chunk channel interfaces for the line bounded access splitter.
interface lbas_req_if import lbas_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ThreadW-1:0] thread_id;
  logic [AddrW-1:0]   access_addr;
  logic [LenW-1:0]    access_bytes;

  modport source (output valid, thread_id, access_addr, access_bytes, input ready);
  modport sink   (input valid, thread_id, access_addr, access_bytes, output ready);
endinterface

interface lbas_chunk_if import lbas_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ThreadW-1:0] chunk_thread;
  logic [AddrW-1:0]   chunk_addr;
  logic [SizeW-1:0]   chunk_bytes;
  logic               chunk_last;

  modport source (output valid, chunk_thread, chunk_addr, chunk_bytes, chunk_last,
                  input ready);
  modport sink   (input valid, chunk_thread, chunk_addr, chunk_bytes, chunk_last,
                  output ready);
endinterface

// ----- design/lbas_datapath.sv -----
// Datapath: access registers, chunk size selection and chunk output register.
module lbas_datapath import lbas_pkg::*; #(
  parameter int LINE_BYTES       = LineBytesDef,
  parameter int MAX_ACCESS_BYTES = MaxAccessBytesDef,
  parameter int ADDR_BITS        = AddrBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lbas_cmd_t          cmd_i,
  output lbas_sts_t          sts_o,
  input  logic [ThreadW-1:0] thread_id_i,
  input  logic [AddrW-1:0]   access_addr_i,
  input  logic [LenW-1:0]    access_bytes_i,
  output logic [ThreadW-1:0] chunk_thread_o,
  output logic [AddrW-1:0]   chunk_addr_o,
  output logic [SizeW-1:0]   chunk_bytes_o,
  output logic               chunk_last_o
);

  localparam int OffW    = $clog2(LINE_BYTES);
  localparam int RoomW   = OffW + 1;
  localparam int CmpW    = (RoomW > LenW) ? RoomW : LenW;
  localparam int MaxClip = (MAX_ACCESS_BYTES > (2 ** LenW - 1)) ? (2 ** LenW - 1)
                                                                 : MAX_ACCESS_BYTES;
  localparam logic [AddrW-1:0] AddrMask =
    (ADDR_BITS >= AddrW) ? {AddrW{1'b1}} : AddrW'((65'(1) << ADDR_BITS) - 65'(1));

  logic [AddrW-1:0]   next_addr_q, next_addr_d;
  logic [LenW-1:0]    bytes_left_q, bytes_left_d;
  logic [ThreadW-1:0] held_thread_q, held_thread_d;

  logic [ThreadW-1:0] out_thread_q;
  logic [AddrW-1:0]   out_addr_q;
  logic [SizeW-1:0]   out_bytes_q;
  logic               out_last_q;

  logic [LenW-1:0]    len_clip;
  logic [RoomW-1:0]   room;
  logic [CmpW-1:0]    lim;
  logic [SizeW-1:0]   sz;
  logic [LenW-1:0]    left_after;

  always_comb begin
    len_clip = (access_bytes_i > LenW'(MaxClip)) ? LenW'(MaxClip) : access_bytes_i;
    room     = RoomW'(LINE_BYTES) - {1'b0, next_addr_q[OffW-1:0]};
    lim      = (CmpW'(bytes_left_q) < CmpW'(room)) ? CmpW'(bytes_left_q) : CmpW'(room);
    if (lim >= CmpW'(8)) begin
      sz = SizeW'(8);
    end else if (lim >= CmpW'(4)) begin
      sz = SizeW'(4);
    end else if (lim >= CmpW'(2)) begin
      sz = SizeW'(2);
    end else begin
      sz = SizeW'(1);
    end
    left_after = bytes_left_q - LenW'(sz);

    next_addr_d   = next_addr_q;
    bytes_left_d  = bytes_left_q;
    held_thread_d = held_thread_q;
    if (cmd_i.load) begin
      next_addr_d   = access_addr_i & AddrMask;
      bytes_left_d  = len_clip;
      held_thread_d = thread_id_i;
    end else if (cmd_i.advance) begin
      next_addr_d  = (next_addr_q + AddrW'(sz)) & AddrMask;
      bytes_left_d = left_after;
    end
  end

  assign sts_o.len_nonzero = (access_bytes_i != '0);
  assign sts_o.last        = (left_after == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_addr_q   <= '0;
      bytes_left_q  <= '0;
      held_thread_q <= '0;
    end else begin
      next_addr_q   <= next_addr_d;
      bytes_left_q  <= bytes_left_d;
      held_thread_q <= held_thread_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      out_thread_q <= held_thread_q;
      out_addr_q   <= next_addr_q;
      out_bytes_q  <= sz;
      out_last_q   <= (left_after == '0);
    end
  end

  assign chunk_thread_o = out_thread_q;
  assign chunk_addr_o   = out_addr_q;
  assign chunk_bytes_o  = out_bytes_q;
  assign chunk_last_o   = out_last_q;

endmodule

// ----- design/lbas_ctrl.sv -----
// Controller: request accept, split sequencing and chunk output valid.
module lbas_ctrl import lbas_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  output logic      chunk_valid_o,
  input  logic      chunk_ready_i,
  input  lbas_sts_t sts_i,
  output lbas_cmd_t cmd_o
);

  typedef enum logic {
    StIdle,
    StSplit
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_emit;

  assign req_ready_o   = (state_q == StIdle);
  assign chunk_valid_o = out_valid_q;
  assign can_emit      = !out_valid_q || chunk_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !chunk_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (req_valid_i && sts_i.len_nonzero) begin
          cmd_o.load = 1'b1;
          state_d    = StSplit;
        end
      end
      StSplit: begin
        if (can_emit) begin
          cmd_o.advance = 1'b1;
          out_valid_d   = 1'b1;
          if (sts_i.last) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_adv_in_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.advance |-> state_q == StSplit)
    else $error("chunk advance outside split");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o && sts_i.len_nonzero) |=> state_q == StSplit)
    else $error("nonzero request did not start a split");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.advance && sts_i.last) |=> (state_q == StIdle && out_valid_q))
    else $error("last chunk did not end the split");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.advance |=> out_valid_q)
    else $error("emitted chunk not presented");

endmodule

// ----- design/line_bounded_access_splitter_top.sv -----
// Top level of the line bounded access splitter.
//
//   channel  dir  payload                                          handshake
//   req_i    in   thread_id, access_addr, access_bytes             valid/ready
//   chunk_o  out  chunk_thread, chunk_addr, chunk_bytes, chunk_last valid/ready
//
// An access is first accepted, then split at one chunk per cycle, while
// chunk_o is not stalled, by the single chunk-size selector; a 64-byte
// access needs up to 11 chunks.
// A zero-length request is taken and gives no chunk.
// Reset is asynchronous, active low; it clears the controller and access state.
// A stall on chunk_o holds the chunk and pauses splitting; a new request is
// taken while the final chunk of the previous one still waits.
module line_bounded_access_splitter_top import lbas_pkg::*; #(
  parameter int LINE_BYTES       = LineBytesDef,
  parameter int MAX_ACCESS_BYTES = MaxAccessBytesDef,
  parameter int ADDR_BITS        = AddrBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lbas_req_if.sink     req_i,
  lbas_chunk_if.source chunk_o
);

  lbas_cmd_t cmd;
  lbas_sts_t sts;

  lbas_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_ready_o   (req_i.ready),
    .chunk_valid_o (chunk_o.valid),
    .chunk_ready_i (chunk_o.ready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  lbas_datapath #(
    .LINE_BYTES       (LINE_BYTES),
    .MAX_ACCESS_BYTES (MAX_ACCESS_BYTES),
    .ADDR_BITS        (ADDR_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .thread_id_i    (req_i.thread_id),
    .access_addr_i  (req_i.access_addr),
    .access_bytes_i (req_i.access_bytes),
    .chunk_thread_o (chunk_o.chunk_thread),
    .chunk_addr_o   (chunk_o.chunk_addr),
    .chunk_bytes_o  (chunk_o.chunk_bytes),
    .chunk_last_o   (chunk_o.chunk_last)
  );

endmodule

// ----- test/lbas_chunk_checker.sv -----
// Checker for the line bounded access splitter: predicts the chunks of each request and compares.
`timescale 1ns / 1ps

module lbas_chunk_checker import lbas_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  lbas_req_if          req_i,
  lbas_chunk_if        chunk_i,
  output int           mismatch_o,
  output int           pending_o
);

  localparam int ReportMax = 10;

  typedef struct packed {
    logic [ThreadW-1:0] tid;
    logic [AddrW-1:0]   addr;
    logic [SizeW-1:0]   nbytes;
    logic               last;
  } chunk_t;

  chunk_t chunk_expect[$];

  // predicted splitter state
  logic [AddrW-1:0]   split_addr   = '0;
  logic [LenW-1:0]    split_left   = '0;
  logic [ThreadW-1:0] split_thread = '0;

  initial begin
    mismatch_o = 0;
    pending_o  = 0;
  end

  function automatic logic [SizeW-1:0] fit_size(int left, int room);
    int lim;
    lim = (left < room) ? left : room;
    if (lim >= 8) return 4'd8;
    if (lim >= 4) return 4'd4;
    if (lim >= 2) return 4'd2;
    return 4'd1;
  endfunction

  task automatic split_access(logic [ThreadW-1:0] tid, logic [AddrW-1:0] addr,
                              logic [LenW-1:0] nbytes);
    int               len;
    int               room;
    logic [SizeW-1:0] sz;
    chunk_t           c;
    len = int'(nbytes);
    if (len > MaxAccessBytesDef) len = MaxAccessBytesDef;
    if (len == 0) return;
    split_thread = tid;
    split_addr   = addr;
    split_left   = LenW'(len);
    while (split_left != 0) begin
      room = LineBytesDef - int'(split_addr % LineBytesDef);
      sz = fit_size(int'(split_left), room);
      split_left = split_left - LenW'(sz);
      c.tid    = split_thread;
      c.addr   = split_addr;
      c.nbytes = sz;
      c.last   = (split_left == 0);
      chunk_expect.push_back(c);
      split_addr = split_addr + AddrW'(sz);
    end
  endtask

  task automatic flag_mismatch(chunk_t want, chunk_t got, bit none);
    mismatch_o++;
    if (mismatch_o <= ReportMax) begin
      if (none)
        $display("%0t: unexpected chunk tid %0d addr %h bytes %0d last %0b", $realtime,
                 got.tid, got.addr, got.nbytes, got.last);
      else begin
        $display("%0t: chunk mismatch: expected tid %0d addr %h bytes %0d last %0b,",
                 $realtime, want.tid, want.addr, want.nbytes, want.last);
        $display("    got tid %0d addr %h bytes %0d last %0b",
                 got.tid, got.addr, got.nbytes, got.last);
      end
    end
  endtask

  always @(posedge clk_i) begin
    chunk_t got;
    chunk_t want;
    if (rst_ni) begin
      if (chunk_i.valid && chunk_i.ready) begin
        got.tid    = chunk_i.chunk_thread;
        got.addr   = chunk_i.chunk_addr;
        got.nbytes = chunk_i.chunk_bytes;
        got.last   = chunk_i.chunk_last;
        if (chunk_expect.size() == 0) begin
          flag_mismatch(got, got, 1'b1);
        end else begin
          want = chunk_expect.pop_front();
          if (want.tid !== got.tid || want.addr !== got.addr ||
              want.nbytes !== got.nbytes || want.last !== got.last)
            flag_mismatch(want, got, 1'b0);
        end
      end
      if (req_i.valid && req_i.ready)
        split_access(req_i.thread_id, req_i.access_addr, req_i.access_bytes);
      pending_o = chunk_expect.size();
    end
  end

endmodule

// ----- test/line_bounded_access_splitter_top_tb.sv -----
// Testbench top for the line bounded access splitter: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module line_bounded_access_splitter_top_tb;
  import lbas_pkg::*;

  localparam int IdleLimit  = 4000;
  localparam int LongHold   = 150;
  localparam int RandomReqs = 180;
  localparam int Drain      = 30;

  logic clk;
  logic rst_n;
  int   mismatch_cnt;
  int   pending_cnt;
  int   idle_cycles = 0;
  bit   src_idle = 1'b1;
  bit   snk_idle = 1'b1;
  bit   hold_long = 1'b0;

  lbas_req_if   req_bus ();
  lbas_chunk_if chunk_bus ();

  line_bounded_access_splitter_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .chunk_o(chunk_bus)
  );

  lbas_chunk_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req_bus),
    .chunk_i   (chunk_bus),
    .mismatch_o(mismatch_cnt),
    .pending_o (pending_cnt)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [AddrW-1:0] rand_addr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: ;
      1: w[5:0] = 6'($urandom_range(48, 63));
      2: w = 64'hFFFF_FFFF_FF00 | 64'($urandom_range(0, 255));
      default: w = 64'($urandom_range(0, 4095));
    endcase
    return w[AddrW-1:0];
  endfunction

  function automatic logic [LenW-1:0] rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return LenW'($urandom_range(65, 127));
    if (r < 30) return LenW'(64);
    return LenW'($urandom_range(1, 63));
  endfunction

  task automatic send_req(logic [ThreadW-1:0] tid, logic [AddrW-1:0] addr,
                          logic [LenW-1:0] nbytes);
    int gap;
    req_bus.valid        <= 1'b1;
    req_bus.thread_id    <= tid;
    req_bus.access_addr  <= addr;
    req_bus.access_bytes <= nbytes;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    @(negedge clk);
    gap = src_idle ? pick_gap() : 0;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // chunk receiver
  initial begin : chunk_sink
    int n;
    chunk_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        chunk_bus.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_long = 1'b0;
      end
      if (snk_idle && $urandom_range(0, 99) < 35) begin
        chunk_bus.ready <= 1'b0;
        n = pick_gap();
        if (n == 0) n = 1;
        repeat (n) @(negedge clk);
      end
      chunk_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_bus.valid && req_bus.ready) || (chunk_bus.valid && chunk_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [AddrW-1:0] a;
    req_bus.valid        = 1'b0;
    req_bus.thread_id    = '0;
    req_bus.access_addr  = '0;
    req_bus.access_bytes = '0;
    rst_n = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // zero length, small, aligned, unaligned, line crossing, clamped, address wrap
    send_req(8'd0,   48'h0000_1234_5678, 7'd0);
    send_req(8'd1,   48'h0,              7'd1);
    send_req(8'd2,   48'h0,              7'd64);
    send_req(8'd3,   48'h0000_0000_103F, 7'd64);
    send_req(8'd4,   48'h0000_0000_2001, 7'd64);
    send_req(8'd5,   48'h0000_0000_3000, 7'd127);
    send_req(8'd6,   48'h0000_0000_3005, 7'd65);
    send_req(8'd7,   48'h0000_0000_403C, 7'd7);
    send_req(8'd8,   48'h0000_0000_503E, 7'd3);
    send_req(8'd9,   48'h0000_0000_6000, 7'd15);
    send_req(8'd10,  48'h0000_0000_7038, 7'd9);
    send_req(8'd255, 48'hFFFF_FFFF_FFFF, 7'd64);
    send_req(8'd128, 48'hFFFF_FFFF_FFC0, 7'd64);
    send_req(8'd170, 48'hFFFF_FFFF_FFFD, 7'd10);
    send_req(8'd255, 48'hFFFF_FFFF_FFFF, 7'd0);
    send_req(8'd85,  48'hAAAA_AAAA_AAAA, 7'd42);
    send_req(8'd0,   48'h5555_5555_5555, 7'd21);
    send_req(8'd255, 48'h0000_0000_0000, 7'd0);

    for (int i = 0; i < RandomReqs; i++) begin
      if (i == 60) begin
        src_idle = 1'b0;
        snk_idle = 1'b0;
      end
      if (i == 100) begin
        src_idle = 1'b1;
        snk_idle = 1'b1;
      end
      if (i == 130) begin
        src_idle  = 1'b0;
        hold_long = 1'b1;
      end
      if (i == 150) src_idle = 1'b1;
      if (i >= 130 && i < 150) begin
        a = rand_addr();
        send_req(8'($urandom), a, 7'd64);
      end else begin
        send_req(8'($urandom), rand_addr(), rand_len());
      end
    end
    req_bus.valid <= 1'b0;

    while (pending_cnt != 0) @(negedge clk);
    repeat (Drain) @(negedge clk);
    if (mismatch_cnt == 0 && pending_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
